@@ hdl/spic_pkg.sv @@
// shared types, widths and codes for the segment pair intersection classifier
// no dependencies; imported by every module of the block
`default_nettype none
package spic_pkg;

  // fixed field widths
  localparam int COORD_BITS = 20;
  localparam int FRAC_BITS  = 16;
  localparam int TOL_FRAC   = 16;

  // configuration register widths
  localparam int PTOL_W    = 16;
  localparam int DTOL_W    = 42;
  localparam int CTOL_W    = 20;
  localparam int CFG_W     = 42;
  localparam int CFG_IDX_W = 2;

  // internal arithmetic widths
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int REM_W  = SUM_W + 1;
  localparam int PE_W   = SUM_W + PTOL_W;
  localparam int CMP_W  = REM_W + TOL_FRAC;
  localparam int EXT_W  = COORD_BITS + 2;

  localparam int QUEUE_DEPTH = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PTOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DTOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CTOL = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_NONE      = 3'd0;
  localparam logic [2:0] KIND_ONE       = 3'd1;
  localparam logic [2:0] KIND_PARALLEL  = 3'd2;
  localparam logic [2:0] KIND_DISJOINT  = 3'd3;
  localparam logic [2:0] KIND_CONTAINED = 3'd4;
  localparam logic [2:0] KIND_OVERLAP   = 3'd5;

  // how the back end forms a parameter
  localparam logic [1:0] MODE_ZERO = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_DIV  = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] bz;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cz;
    logic signed [COORD_BITS-1:0] dx;
    logic signed [COORD_BITS-1:0] dz;
  } seg_pair_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [FRAC_BITS:0]   alpha_out;
    logic [FRAC_BITS:0]   beta_out;
  } isect_t;

  typedef struct packed {
    logic [PTOL_W-1:0] ptol;
    logic [DTOL_W-1:0] dtol;
    logic [CTOL_W-1:0] ctol;
  } tol_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [2:0]       kind;
    logic [1:0]       a_mode;
    logic [1:0]       b_mode;
    logic [SUM_W-1:0] a_num;
    logic [SUM_W-1:0] b_num;
    logic [SUM_W-1:0] den;
  } job_t;

endpackage
`default_nettype wire

@@ hdl/spic_front.sv @@
// front end: differences, cross products, tolerance tests and classification
// depends on spic_pkg; feeds spic_queue with one job per accepted transaction
`default_nettype none
module spic_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_take,
  input  wire spic_pkg::seg_pair_t in_data,
  input  wire spic_pkg::tol_t     tol,
  output logic                    job_valid,
  output spic_pkg::job_t          job
);
  import spic_pkg::*;

  typedef struct packed {
    logic       ok;
    logic [1:0] mode;
  } chk_t;

  // exact tolerance window test and clamp selection for num/den, den > 0
  function automatic chk_t check_param(input logic signed [SUM_W-1:0] num,
                                       input logic [SUM_W-1:0] den,
                                       input logic [PE_W-1:0] e_den);
    logic                    pos;
    logic [SUM_W-1:0]        neg_mag;
    logic signed [REM_W-1:0] t;
    logic                    lo_ok;
    logic                    hi_ok;
    chk_t                    res;
    pos     = !num[SUM_W-1] && (num != '0);
    neg_mag = SUM_W'(-num);
    t       = REM_W'(num) - $signed(REM_W'(den));
    lo_ok   = pos || ((CMP_W'(neg_mag) << TOL_FRAC) < CMP_W'(e_den));
    hi_ok   = t[REM_W-1] || ((CMP_W'($unsigned(t)) << TOL_FRAC) < CMP_W'(e_den));
    res.ok  = lo_ok && hi_ok;
    if (!pos) res.mode = MODE_ZERO;
    else if (!t[REM_W-1]) res.mode = MODE_ONE;
    else res.mode = MODE_DIV;
    return res;
  endfunction

  // stage a: differences and projection extents
  logic                         va_r;
  logic signed [DIFF_W-1:0]     dxc_r, dzc_r, azc_r, axc_r, bxa_r, bza_r;
  logic signed [COORD_BITS-1:0] abl_r, abh_r, cdl_r, cdh_r;

  logic signed [DIFF_W-1:0]     bxa_c;
  logic [DIFF_W-1:0]            bxa_mag;
  logic                         use_x;
  logic signed [COORD_BITS-1:0] p_c, q_c, r_c, s_c;

  always_comb begin
    bxa_c   = DIFF_W'(in_data.bx) - DIFF_W'(in_data.ax);
    bxa_mag = bxa_c[DIFF_W-1] ? DIFF_W'(-bxa_c) : DIFF_W'(bxa_c);
    use_x   = EXT_W'(bxa_mag) > EXT_W'(tol.ctol);
    p_c = use_x ? in_data.ax : in_data.az;
    q_c = use_x ? in_data.bx : in_data.bz;
    r_c = use_x ? in_data.cx : in_data.cz;
    s_c = use_x ? in_data.dx : in_data.dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else va_r <= in_take;
    dxc_r <= DIFF_W'(in_data.dx) - DIFF_W'(in_data.cx);
    dzc_r <= DIFF_W'(in_data.dz) - DIFF_W'(in_data.cz);
    azc_r <= DIFF_W'(in_data.az) - DIFF_W'(in_data.cz);
    axc_r <= DIFF_W'(in_data.ax) - DIFF_W'(in_data.cx);
    bxa_r <= bxa_c;
    bza_r <= DIFF_W'(in_data.bz) - DIFF_W'(in_data.az);
    abl_r <= (p_c < q_c) ? p_c : q_c;
    abh_r <= (p_c < q_c) ? q_c : p_c;
    cdl_r <= (r_c < s_c) ? r_c : s_c;
    cdh_r <= (r_c < s_c) ? s_c : r_c;
  end

  // stage b: six products and the collinear extent verdict
  logic                     vb_r;
  logic signed [PROD_W-1:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic [2:0]               extb_r;

  logic signed [EXT_W-1:0]  tol_s;
  logic                     disjoint, contained;
  logic [2:0]               ext_c;

  always_comb begin
    tol_s     = $signed(EXT_W'(tol.ctol));
    disjoint  = (EXT_W'(cdh_r) + tol_s < EXT_W'(abl_r)) ||
                (EXT_W'(abh_r) + tol_s < EXT_W'(cdl_r));
    contained = ((abl_r <= cdl_r) && (cdh_r <= abh_r)) ||
                ((cdl_r <= abl_r) && (abh_r <= cdh_r));
    if (disjoint) ext_c = KIND_DISJOINT;
    else if (contained) ext_c = KIND_CONTAINED;
    else ext_c = KIND_OVERLAP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else vb_r <= va_r;
    p1_r   <= dxc_r * azc_r;
    p2_r   <= dzc_r * axc_r;
    p3_r   <= bxa_r * azc_r;
    p4_r   <= bza_r * axc_r;
    p5_r   <= bxa_r * dzc_r;
    p6_r   <= bza_r * dxc_r;
    extb_r <= ext_c;
  end

  // stage c: numerators and determinant
  logic                    vc_r;
  logic signed [SUM_W-1:0] nab_r, ncd_r, det_r;
  logic [2:0]              extc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else vc_r <= vb_r;
    nab_r  <= SUM_W'(p1_r) - SUM_W'(p2_r);
    ncd_r  <= SUM_W'(p3_r) - SUM_W'(p4_r);
    det_r  <= SUM_W'(p5_r) - SUM_W'(p6_r);
    extc_r <= extb_r;
  end

  // stage d: magnitudes, sign fold, tolerance product
  logic                    vd_r;
  logic signed [SUM_W-1:0] na_r, nc_r;
  logic [SUM_W-1:0]        den_r;
  logic [PE_W-1:0]         eden_r;
  logic                    big_r, par_r;
  logic [2:0]              extd_r;

  logic [SUM_W-1:0] det_mag, nab_mag, ncd_mag;
  logic [CMP_W-1:0] dtol_x;

  always_comb begin
    det_mag = det_r[SUM_W-1] ? SUM_W'(-det_r) : SUM_W'(det_r);
    nab_mag = nab_r[SUM_W-1] ? SUM_W'(-nab_r) : SUM_W'(nab_r);
    ncd_mag = ncd_r[SUM_W-1] ? SUM_W'(-ncd_r) : SUM_W'(ncd_r);
    dtol_x  = CMP_W'(tol.dtol);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else vd_r <= vc_r;
    na_r   <= det_r[SUM_W-1] ? -nab_r : nab_r;
    nc_r   <= det_r[SUM_W-1] ? -ncd_r : ncd_r;
    den_r  <= det_mag;
    eden_r <= PE_W'(tol.ptol) * PE_W'(det_mag);
    big_r  <= CMP_W'(det_mag) > dtol_x;
    par_r  <= (CMP_W'(nab_mag) > dtol_x) && (CMP_W'(ncd_mag) > dtol_x);
    extd_r <= extc_r;
  end

  // stage e: final verdict
  chk_t a_chk, b_chk;
  job_t job_c;

  always_comb begin
    a_chk       = check_param(na_r, den_r, eden_r);
    b_chk       = check_param(nc_r, den_r, eden_r);
    job_c.a_num = $unsigned(na_r);
    job_c.b_num = $unsigned(nc_r);
    job_c.den   = den_r;
    job_c.a_mode = MODE_ZERO;
    job_c.b_mode = MODE_ZERO;
    if (big_r) begin
      if (a_chk.ok && b_chk.ok) begin
        job_c.kind   = KIND_ONE;
        job_c.a_mode = a_chk.mode;
        job_c.b_mode = b_chk.mode;
      end else begin
        job_c.kind = KIND_NONE;
      end
    end else if (par_r) begin
      job_c.kind = KIND_PARALLEL;
    end else begin
      job_c.kind = extd_r;
    end
  end

  logic ve_r;
  job_t job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else ve_r <= vd_r;
    job_r <= job_c;
  end

  assign job_valid = ve_r;
  assign job       = job_r;

endmodule
`default_nettype wire

@@ hdl/spic_queue.sv @@
// short job queue between front and back end
// depends on spic_pkg for the job type
`default_nettype none
module spic_queue #(
  parameter int DEPTH = spic_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire spic_pkg::job_t push_data,
  output logic                pop,
  output spic_pkg::job_t      pop_data
);
  import spic_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] count_r;
  logic          full, do_push;

  assign full     = (count_r == CW'(DEPTH));
  assign do_push  = push && !full;
  assign pop      = (count_r != '0);
  assign pop_data = mem[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      if (pop) rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      count_r <= count_r + CW'(do_push) - CW'(pop);
    end
  end

`ifndef SYNTHESIS
  // back end drains every cycle, so the queue never fills
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("job queue overflow");
  a_shallow: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(1))
    else $error("job queue holds more than one job");
`endif

endmodule
`default_nettype wire

@@ hdl/spic_back.sv @@
// back end: pipelined restoring division of both parameters, rounding, clamp
// depends on spic_pkg; takes jobs from spic_queue, one per cycle
`default_nettype none
module spic_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  input  wire spic_pkg::job_t job,
  output logic                res_valid,
  output spic_pkg::isect_t    res
);
  import spic_pkg::*;

  function automatic logic [FRAC_BITS:0] pick(input logic [1:0] mode,
                                              input logic [FRAC_BITS-1:0] q,
                                              input logic rnd);
    logic [FRAC_BITS:0] v;
    case (mode)
      MODE_ONE: v = (FRAC_BITS+1)'(1) << FRAC_BITS;
      MODE_DIV: v = (FRAC_BITS+1)'(q) + (FRAC_BITS+1)'(rnd);
      default:  v = '0;
    endcase
    return v;
  endfunction

  logic [FRAC_BITS:0]   v_r;
  logic [REM_W-1:0]     ar_r [FRAC_BITS+1];
  logic [REM_W-1:0]     br_r [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] aq_r [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] bq_r [FRAC_BITS+1];
  logic [SUM_W-1:0]     dn_r [FRAC_BITS+1];
  logic [2:0]           kd_r [FRAC_BITS+1];
  logic [1:0]           am_r [FRAC_BITS+1];
  logic [1:0]           bm_r [FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else v_r[0] <= job_valid;
    ar_r[0] <= REM_W'(job.a_num);
    br_r[0] <= REM_W'(job.b_num);
    aq_r[0] <= '0;
    bq_r[0] <= '0;
    dn_r[0] <= job.den;
    kd_r[0] <= job.kind;
    am_r[0] <= job.a_mode;
    bm_r[0] <= job.b_mode;
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_div
    logic [REM_W-1:0] a_sh, b_sh, d_x;
    logic             a_ge, b_ge;
    always_comb begin
      a_sh = {ar_r[k-1][REM_W-2:0], 1'b0};
      b_sh = {br_r[k-1][REM_W-2:0], 1'b0};
      d_x  = REM_W'(dn_r[k-1]);
      a_ge = a_sh >= d_x;
      b_ge = b_sh >= d_x;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else v_r[k] <= v_r[k-1];
      ar_r[k] <= a_ge ? a_sh - d_x : a_sh;
      br_r[k] <= b_ge ? b_sh - d_x : b_sh;
      aq_r[k] <= {aq_r[k-1][FRAC_BITS-2:0], a_ge};
      bq_r[k] <= {bq_r[k-1][FRAC_BITS-2:0], b_ge};
      dn_r[k] <= dn_r[k-1];
      kd_r[k] <= kd_r[k-1];
      am_r[k] <= am_r[k-1];
      bm_r[k] <= bm_r[k-1];
    end
  end

  // round to nearest, ties upward
  logic [REM_W:0] d_last;
  logic           a_rnd, b_rnd;
  isect_t         res_c;

  always_comb begin
    d_last          = (REM_W+1)'(dn_r[FRAC_BITS]);
    a_rnd           = {ar_r[FRAC_BITS], 1'b0} >= d_last;
    b_rnd           = {br_r[FRAC_BITS], 1'b0} >= d_last;
    res_c.kind      = kd_r[FRAC_BITS];
    res_c.alpha_out = pick(am_r[FRAC_BITS], aq_r[FRAC_BITS], a_rnd);
    res_c.beta_out  = pick(bm_r[FRAC_BITS], bq_r[FRAC_BITS], b_rnd);
  end

  logic   res_valid_r;
  isect_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) res_valid_r <= 1'b0;
    else res_valid_r <= v_r[FRAC_BITS];
    res_r <= res_c;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

@@ hdl/segment_pair_intersection_classifier.sv @@
// top level of the segment pair intersection classifier
// throughput: one transaction per cycle, busy stays low; every front stage,
//   the queue slots and each divider stage are registers, nothing is shared
// reset: rst_n synchronous, active low; clears all valid bits and the queue,
//   tolerance registers return to 1; the receiver cannot stall results
`default_nettype none
module segment_pair_intersection_classifier #(
  parameter int QUEUE_DEPTH = spic_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             start,
  output logic                                  busy,
  input  wire spic_pkg::seg_pair_t              in_data,
  // result channel, one-cycle strobe
  output logic                                  out_valid,
  output spic_pkg::isect_t                      out_data,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [spic_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [spic_pkg::CFG_W-1:0]       cfg_wdata
);
  import spic_pkg::*;

  // tolerance registers; the user must write them only while idle, the block does not enforce it
  tol_t tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r.ptol <= PTOL_W'(1);
      tol_r.dtol <= DTOL_W'(1);
      tol_r.ctol <= CTOL_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PTOL: tol_r.ptol <= cfg_wdata[PTOL_W-1:0];
        CFG_DTOL: tol_r.dtol <= cfg_wdata[DTOL_W-1:0];
        CFG_CTOL: tol_r.ctol <= cfg_wdata[CTOL_W-1:0];
        default:  ;
      endcase
    end
  end

  // fully pipelined, so a new transaction is taken every cycle
  logic in_take;
  assign busy    = 1'b0;
  assign in_take = start && !busy;

  // front end: cross products and classification
  logic front_valid;
  job_t front_job;

  spic_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_data   (in_data),
    .tol       (tol_r),
    .job_valid (front_valid),
    .job       (front_job)
  );

  // decoupling queue
  logic q_pop;
  job_t q_job;

  spic_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_data (front_job),
    .pop       (q_pop),
    .pop_data  (q_job)
  );

  // back end: parameter division and output register
  spic_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_pop),
    .job       (q_job),
    .res_valid (out_valid),
    .res       (out_data)
  );

`ifndef SYNTHESIS
  // every transaction comes out after the fixed pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
      in_take |-> ##(FRAC_BITS + 8) out_valid)
    else $error("result missing at expected latency");
  // parameters are zero unless there is one crossing
  a_zero_params: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && (out_data.kind != KIND_ONE)) |->
        ((out_data.alpha_out == '0) && (out_data.beta_out == '0)))
    else $error("nonzero parameter without a crossing");
`endif

endmodule
`default_nettype wire
